// ===== rtl/flcb_pkg.sv =====
// ----------------------------------------------------------------------------
// flcb_pkg
// shared types and constants for the fly camera basis unit
// ----------------------------------------------------------------------------
package flcb_pkg;

  localparam int unsigned FullTurn    = 23040;
  localparam int unsigned HalfTurn    = 11520;
  localparam int unsigned QuarterTurn = 5760;
  localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;
  localparam int unsigned MaxSteps    = 24;

  // turn count estimate: ((angle + half turn) >>> 9) * WrapRecip >>> WrapShift
  localparam logic signed [15:0] WrapRecip = 16'sd23302;
  localparam int unsigned        WrapShift = 20;

  typedef enum logic [3:0] {
    OP_FWD       = 4'd0,
    OP_BACK      = 4'd1,
    OP_RIGHT     = 4'd2,
    OP_LEFT      = 4'd3,
    OP_ADD_X     = 4'd4,
    OP_ADD_Y     = 4'd5,
    OP_ADD_Z     = 4'd6,
    OP_SET_X     = 4'd7,
    OP_SET_Y     = 4'd8,
    OP_SET_Z     = 4'd9,
    OP_ADD_YAW   = 4'd10,
    OP_ADD_PITCH = 4'd11,
    OP_SET_YAW   = 4'd12,
    OP_SET_PITCH = 4'd13,
    OP_NOP14     = 4'd14,
    OP_NOP15     = 4'd15
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOVE,
    ST_RED,
    ST_WRAP,
    ST_COR_START,
    ST_COR_RUN,
    ST_COR_DONE,
    ST_MUL,
    ST_OUT
  } state_e;

  // cordic start request and result
  typedef struct packed {
    logic               start;
    logic signed [14:0] angle;
  } cor_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
  } cor_rsp_t;

  function automatic logic [31:0] atan_deg16(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'd2949120;
        5'd1:  r = 32'd1740967;
        5'd2:  r = 32'd919879;
        5'd3:  r = 32'd466945;
        5'd4:  r = 32'd234379;
        5'd5:  r = 32'd117304;
        5'd6:  r = 32'd58666;
        5'd7:  r = 32'd29335;
        5'd8:  r = 32'd14668;
        5'd9:  r = 32'd7334;
        5'd10: r = 32'd3667;
        5'd11: r = 32'd1833;
        5'd12: r = 32'd917;
        5'd13: r = 32'd458;
        5'd14: r = 32'd229;
        5'd15: r = 32'd115;
        5'd16: r = 32'd57;
        5'd17: r = 32'd29;
        5'd18: r = 32'd14;
        5'd19: r = 32'd7;
        5'd20: r = 32'd4;
        5'd21: r = 32'd2;
        5'd22: r = 32'd1;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/free_look_camera_basis_unit.sv =====
// ----------------------------------------------------------------------------
// free_look_camera_basis_unit
// fly camera: one command in, position and front/right/up basis out
// ----------------------------------------------------------------------------
// One command is taken at a time. A command runs a sequencer that does a
// move step (one 16x32 product per axis for moves, a single update for
// other commands), an estimate of the angle turn count on the shared
// multiplier, an angle wrap with single-turn fix-ups until the angle is in
// range, then two runs of the shared CORDIC unit (yaw, then pitch), then
// the basis products on the shared multiplier. Set yaw, set pitch and
// unused codes skip the CORDIC runs and the basis products and give their
// result straight after the wrap. s_axis_tready is low during the basis
// refresh after reset and from accept until the result transaction
// completes on the master side.
module free_look_camera_basis_unit #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [12:0]   cfg_wdata_i,     // pitch_limit
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [39:0]   s_axis_tdata,    // op[3:0], amount[35:4], zero pad
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [239:0]  m_axis_tdata     // pos_x, pos_y, pos_z (32 each),
                                         // front, right, up x/y/z (16 each)
);

  flcb_pkg::state_e   st_q, st_d;
  logic [12:0]        lim_q;
  logic [3:0]         op_q;
  logic signed [31:0] amt_q;
  logic signed [15:0] yaw_q, pit_q;
  logic signed [31:0] pos_q [3];
  logic signed [15:0] fv_q [3], rv_q [3], uv_q [3];
  logic signed [15:0] sy_q, cy_q, sp_q, cp_q;
  logic [1:0]         k_q;
  logic               ph_q;
  logic               refr_q;
  logic signed [15:0] ma;
  logic signed [31:0] mb;
  logic signed [47:0] prod, rp;
  logic signed [33:0] acc;
  logic signed [31:0] sat;
  logic signed [33:0] wsum;
  logic signed [33:0] psum, plim;
  logic signed [33:0] wacc_q;
  logic signed [33:0] wdiv, wq, wqm;
  flcb_pkg::cor_req_t creq;
  flcb_pkg::cor_rsp_t crsp;
  logic signed [15:0] cyv, syv, spv, cpv;
  logic signed [15:0] mr16;

  flcb_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (creq),
    .rsp_o (crsp)
  );

  assign s_axis_tready = (st_q == flcb_pkg::ST_IDLE) && refr_q;
  assign m_axis_tvalid = (st_q == flcb_pkg::ST_OUT);

  assign wdiv = (wacc_q + 34'sd11520) >>> 9;

  // shared multiplier
  always_comb begin
    ma = 16'sd0;
    mb = 32'sd0;
    if (st_q == flcb_pkg::ST_MOVE) begin
      ma = (op_q == flcb_pkg::OP_FWD || op_q == flcb_pkg::OP_BACK) ? fv_q[k_q] : rv_q[k_q];
      mb = amt_q;
    end else if (st_q == flcb_pkg::ST_RED) begin
      ma = flcb_pkg::WrapRecip;
      mb = wdiv[31:0];
    end else begin
      case (k_q)
        2'd0:    begin ma = cy_q; mb = 32'(cp_q); end
        2'd1:    begin ma = sy_q; mb = 32'(cp_q); end
        2'd2:    begin ma = cy_q; mb = 32'(sp_q); end
        default: begin ma = sy_q; mb = 32'(sp_q); end
      endcase
    end
  end
  assign prod = 48'(ma) * 48'(mb);
  assign rp   = (prod + 48'sd8192) >>> 14;
  assign mr16 = rp[15:0];

  // turn count estimate times 23040 = 16384 + 4096 + 2048 + 512
  assign wq  = 34'(prod >>> flcb_pkg::WrapShift);
  assign wqm = (wq <<< 14) + (wq <<< 12) + (wq <<< 11) + (wq <<< 9);

  always_comb begin
    if (op_q == flcb_pkg::OP_BACK || op_q == flcb_pkg::OP_LEFT)
      acc = 34'(pos_q[k_q]) - 34'(rp);
    else
      acc = 34'(pos_q[k_q]) + 34'(rp);
  end
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    else if (v < -34'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction
  assign sat = sat32(acc);

  // angle wrap: reciprocal estimate of the turn count, then single-turn fix-up
  assign wsum = (op_q == flcb_pkg::OP_ADD_YAW) ? 34'(yaw_q) + 34'(amt_q) : 34'(amt_q);
  assign psum = 34'(pit_q) + 34'(amt_q);
  assign plim = (lim_q > 13'd5760) ? 34'sd5760 : 34'(lim_q);

  assign cyv = cy_q;
  assign syv = sy_q;
  assign spv = sp_q;
  assign cpv = cp_q;

  always_comb begin
    st_d  = st_q;
    creq.start = 1'b0;
    creq.angle = ph_q ? 15'(pit_q) : 15'(yaw_q);
    case (st_q)
      flcb_pkg::ST_IDLE:     if (!refr_q) st_d = flcb_pkg::ST_COR_START;
                             else if (s_axis_tvalid) st_d = flcb_pkg::ST_MOVE;
      flcb_pkg::ST_MOVE:     if (k_q == 2'd2 || op_q > flcb_pkg::OP_LEFT) st_d = flcb_pkg::ST_RED;
      flcb_pkg::ST_RED:      st_d = flcb_pkg::ST_WRAP;
      flcb_pkg::ST_WRAP: begin
        if (wacc_q >= 34'sd11520 || wacc_q < -34'sd11520) st_d = flcb_pkg::ST_WRAP;
        else if (op_q >= flcb_pkg::OP_SET_YAW) st_d = flcb_pkg::ST_OUT;
        else st_d = flcb_pkg::ST_COR_START;
      end
      flcb_pkg::ST_COR_START: begin
        creq.start = 1'b1;
        st_d = flcb_pkg::ST_COR_RUN;
      end
      flcb_pkg::ST_COR_RUN:  st_d = flcb_pkg::ST_COR_DONE;
      flcb_pkg::ST_COR_DONE: if (crsp.done) st_d = ph_q ? flcb_pkg::ST_MUL : flcb_pkg::ST_COR_START;
      flcb_pkg::ST_MUL:      if (k_q == 2'd3) st_d = refr_q ? flcb_pkg::ST_OUT : flcb_pkg::ST_IDLE;
      flcb_pkg::ST_OUT:      if (m_axis_tready) st_d = flcb_pkg::ST_IDLE;
      default:               st_d = flcb_pkg::ST_IDLE;
    endcase
  end

  logic signed [15:0] sg_cp;
  assign sg_cp = cp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= flcb_pkg::ST_IDLE;
      lim_q  <= 13'd5696;
      yaw_q  <= -16'sd64;
      pit_q  <= 16'sd0;
      pos_q[0] <= '0; pos_q[1] <= '0; pos_q[2] <= '0;
      k_q    <= '0;
      ph_q   <= 1'b0;
      refr_q <= 1'b0;
      op_q   <= flcb_pkg::OP_NOP14;
      wacc_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) lim_q <= cfg_wdata_i;
      case (st_q)
        flcb_pkg::ST_IDLE: begin
          k_q <= '0;
          ph_q <= 1'b0;
          if (refr_q && s_axis_tvalid) begin
            op_q  <= s_axis_tdata[3:0];
          end
        end
        flcb_pkg::ST_MOVE: begin
          k_q <= k_q + 2'd1;
          case (op_q)
            flcb_pkg::OP_FWD, flcb_pkg::OP_BACK,
            flcb_pkg::OP_RIGHT, flcb_pkg::OP_LEFT: pos_q[k_q] <= sat;
            flcb_pkg::OP_ADD_X: pos_q[0] <= sat32(34'(pos_q[0]) + 34'(amt_q));
            flcb_pkg::OP_ADD_Y: pos_q[1] <= sat32(34'(pos_q[1]) + 34'(amt_q));
            flcb_pkg::OP_ADD_Z: pos_q[2] <= sat32(34'(pos_q[2]) + 34'(amt_q));
            flcb_pkg::OP_SET_X: pos_q[0] <= amt_q;
            flcb_pkg::OP_SET_Y: pos_q[1] <= amt_q;
            flcb_pkg::OP_SET_Z: pos_q[2] <= amt_q;
            flcb_pkg::OP_ADD_PITCH: begin
              if (psum > plim) pit_q <= 16'(plim);
              else if (psum < -plim) pit_q <= 16'(-plim);
              else pit_q <= 16'(psum);
            end
            default: ;
          endcase
          wacc_q <= wsum;
        end
        flcb_pkg::ST_RED: wacc_q <= wacc_q - wqm;
        flcb_pkg::ST_WRAP: begin
          k_q <= '0;
          if (wacc_q >= 34'sd11520)
            wacc_q <= wacc_q - 34'sd23040;
          else if (wacc_q < -34'sd11520)
            wacc_q <= wacc_q + 34'sd23040;
          else if (op_q == flcb_pkg::OP_ADD_YAW || op_q == flcb_pkg::OP_SET_YAW)
            yaw_q <= wacc_q[15:0];
          else if (op_q == flcb_pkg::OP_SET_PITCH)
            pit_q <= wacc_q[15:0];
        end
        flcb_pkg::ST_COR_DONE: if (crsp.done) begin
          ph_q <= 1'b1;
          if (ph_q) begin sp_q <= crsp.sin_v; cp_q <= crsp.cos_v; end
          else begin sy_q <= crsp.sin_v; cy_q <= crsp.cos_v; end
        end
        flcb_pkg::ST_MUL: begin
          k_q <= k_q + 2'd1;
          case (k_q)
            2'd0: fv_q[0] <= mr16;
            2'd1: fv_q[2] <= mr16;
            2'd2: uv_q[0] <= (sg_cp == 16'sd0) ? 16'sd0 : (sg_cp[15] ? mr16 : -mr16);
            default: begin
              uv_q[2] <= (sg_cp == 16'sd0) ? 16'sd0 : (sg_cp[15] ? mr16 : -mr16);
              fv_q[1] <= spv;
              rv_q[0] <= (sg_cp == 16'sd0) ? 16'sd0 : (sg_cp[15] ? syv : -syv);
              rv_q[1] <= 16'sd0;
              rv_q[2] <= (sg_cp == 16'sd0) ? 16'sd0 : (sg_cp[15] ? -cyv : cyv);
              uv_q[1] <= (sg_cp == 16'sd0) ? 16'sd0 : (sg_cp[15] ? -cpv : cpv);
              refr_q  <= 1'b1;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == flcb_pkg::ST_IDLE && refr_q && s_axis_tvalid) amt_q <= s_axis_tdata[35:4];
  end

  assign m_axis_tdata = {uv_q[2], uv_q[1], uv_q[0],
                         rv_q[2], rv_q[1], rv_q[0],
                         fv_q[2], fv_q[1], fv_q[0],
                         pos_q[2], pos_q[1], pos_q[0]};

endmodule

// ===== rtl/flcb_cordic.sv =====
// ----------------------------------------------------------------------------
// flcb_cordic
// iterative cordic sine and cosine, one rotation step per cycle
// ----------------------------------------------------------------------------
module flcb_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  flcb_pkg::cor_req_t req_i,
  output flcb_pkg::cor_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(CORDIC_STEPS + 1);

  logic                busy_q, busy_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                flip_q, flip_d;
  logic signed [33:0]  x_q, x_d, y_q, y_d;
  logic signed [33:0]  z_q, z_d;
  logic signed [15:0]  a16;
  logic signed [33:0]  dx, dy, at, xr, yr;
  logic signed [17:0]  xs, ys;
  logic signed [15:0]  xc, yc;
  logic [4:0]          idx;

  assign idx = 5'(cnt_q);
  assign dx  = y_q >>> idx;
  assign dy  = x_q >>> idx;
  assign at  = 34'(flcb_pkg::atan_deg16(idx));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    flip_d = flip_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    a16 = 16'(req_i.angle);
    if (req_i.start) begin
      flip_d = 1'b0;
      if (a16 > 16'sd5760) begin
        a16 = a16 - 16'sd11520;
        flip_d = 1'b1;
      end else if (a16 < -16'sd5760) begin
        a16 = a16 + 16'sd11520;
        flip_d = 1'b1;
      end
      x_d = flcb_pkg::CordicGainQ30;
      y_d = '0;
      z_d = 34'(a16) <<< 10;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(CORDIC_STEPS - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flip_q <= flip_d;
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign xr = (x_q + 34'sd32768) >>> 16;
  assign yr = (y_q + 34'sd32768) >>> 16;
  assign xs = xr[17:0];
  assign ys = yr[17:0];
  assign xc = (xs > 18'sd16384) ? 16'sd16384 :
              (xs < -18'sd16384) ? -16'sd16384 : xs[15:0];
  assign yc = (ys > 18'sd16384) ? 16'sd16384 :
              (ys < -18'sd16384) ? -16'sd16384 : ys[15:0];

  assign rsp_o.done  = !busy_q;
  assign rsp_o.cos_v = flip_q ? -xc : xc;
  assign rsp_o.sin_v = flip_q ? -yc : yc;

endmodule

// ===== test/free_look_camera_basis_unit_test.sv =====
// ----------------------------------------------------------------------------
// free_look_camera_basis_unit_test
// self-checking bench for the fly camera basis unit: commands are driven on
// the input stream, each is run through a behavioural camera model, and every
// output transaction is compared field by field, position included, with the predicted basis
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module free_look_camera_basis_unit_test;

  localparam int Steps = 16;
  localparam longint GainQ30 = 652032874;
  localparam longint FullTurn = longint'(flcb_pkg::FullTurn);
  localparam longint HalfTurn = longint'(flcb_pkg::HalfTurn);
  localparam longint QuarterTurn = longint'(flcb_pkg::QuarterTurn);

  typedef struct packed {
    flcb_pkg::op_e op;
    logic [31:0]   amount;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
  } view_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [12:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [239:0] m_axis_tdata;

  cmd_t   cmd_q[$];
  view_t  view_q[$];
  int     send_idle = 0, recv_idle = 0;
  int     errors = 0;

  // camera model state
  longint yaw, pitch, limit;
  longint pos[3], fv[3], rv[3], uv[3];

  free_look_camera_basis_unit #(.CORDIC_STEPS(Steps)) i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd14(longint p);
    return (p + 8192) >>> 14;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic longint wrap_angle(longint v);
    longint r;
    r = (v + HalfTurn) % FullTurn;
    if (r < 0) r += FullTurn;
    return r - HalfTurn;
  endfunction

  task automatic sin_cos(input longint a, output longint s, output longint c);
    bit     flip;
    longint x, y, z, dx, dy;
    flip = 0;
    x = GainQ30;
    y = 0;
    if (a > QuarterTurn) begin
      a -= HalfTurn; flip = 1;
    end else if (a < -QuarterTurn) begin
      a += HalfTurn; flip = 1;
    end
    z = a * 1024;
    for (int i = 0; i < Steps; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(flcb_pkg::atan_deg16(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(flcb_pkg::atan_deg16(i[4:0]));
      end
    end
    x = clamp_unit(asr(x + 32768, 16));
    y = clamp_unit(asr(y + 32768, 16));
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  task automatic refresh_basis();
    longint sy, cy, sp, cp, sg;
    sin_cos(yaw, sy, cy);
    sin_cos(pitch, sp, cp);
    sg = (cp > 0) ? 1 : ((cp < 0) ? -1 : 0);
    fv[0] = rnd14(cy * cp); fv[1] = sp; fv[2] = rnd14(sy * cp);
    rv[0] = -sg * sy; rv[1] = 0; rv[2] = sg * cy;
    uv[0] = -sg * rnd14(cy * sp); uv[1] = sg * cp; uv[2] = -sg * rnd14(sy * sp);
  endtask

  task automatic move_along(input bit use_right, input longint amt, input bit neg);
    longint d;
    for (int k = 0; k < 3; k++) begin
      d = rnd14((use_right ? rv[k] : fv[k]) * amt);
      pos[k] = sat32(neg ? pos[k] - d : pos[k] + d);
    end
  endtask

  task automatic apply_command(input cmd_t c);
    longint amt, lim, p;
    view_t  v;
    amt = longint'($signed(c.amount));
    lim = (limit > QuarterTurn) ? QuarterTurn : limit;
    case (c.op)
      flcb_pkg::OP_FWD: begin move_along(0, amt, 0); refresh_basis(); end
      flcb_pkg::OP_BACK: begin move_along(0, amt, 1); refresh_basis(); end
      flcb_pkg::OP_RIGHT: begin move_along(1, amt, 0); refresh_basis(); end
      flcb_pkg::OP_LEFT: begin move_along(1, amt, 1); refresh_basis(); end
      flcb_pkg::OP_ADD_X, flcb_pkg::OP_ADD_Y, flcb_pkg::OP_ADD_Z: begin
        pos[c.op - flcb_pkg::OP_ADD_X] = sat32(pos[c.op - flcb_pkg::OP_ADD_X] + amt);
        refresh_basis();
      end
      flcb_pkg::OP_SET_X, flcb_pkg::OP_SET_Y, flcb_pkg::OP_SET_Z: begin
        pos[c.op - flcb_pkg::OP_SET_X] = amt;
        refresh_basis();
      end
      flcb_pkg::OP_ADD_YAW: begin yaw = wrap_angle(yaw + amt); refresh_basis(); end
      flcb_pkg::OP_ADD_PITCH: begin
        p = pitch + amt;
        if (p > lim) p = lim;
        if (p < -lim) p = -lim;
        pitch = p;
        refresh_basis();
      end
      flcb_pkg::OP_SET_YAW: yaw = wrap_angle(amt);
      flcb_pkg::OP_SET_PITCH: pitch = wrap_angle(amt);
      default: ;
    endcase
    v.px = 32'(pos[0]); v.py = 32'(pos[1]); v.pz = 32'(pos[2]);
    v.fx = 16'(fv[0]); v.fy = 16'(fv[1]); v.fz = 16'(fv[2]);
    v.rx = 16'(rv[0]); v.ry = 16'(rv[1]); v.rz = 16'(rv[2]);
    v.ux = 16'(uv[0]); v.uy = 16'(uv[1]); v.uz = 16'(uv[2]);
    view_q.push_back(v);
  endtask

  function automatic view_t unpack_view(logic [239:0] d);
    view_t v;
    v.px = d[31:0];    v.py = d[63:32];   v.pz = d[95:64];
    v.fx = d[111:96];  v.fy = d[127:112]; v.fz = d[143:128];
    v.rx = d[159:144]; v.ry = d[175:160]; v.rz = d[191:176];
    v.ux = d[207:192]; v.uy = d[223:208]; v.uz = d[239:224];
    return v;
  endfunction

  // driver
  always @(posedge clk_i) begin
    cmd_t c;
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_axis_tvalid) apply_command(cmd_q.pop_front());
        if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          c = cmd_q[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, c.amount, c.op};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    view_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = unpack_view(m_axis_tdata);
      if (view_q.size() == 0) begin
        $display("%0t unexpected transaction %h", $time, got);
        errors++;
      end else begin
        want = view_q.pop_front();
        if (got.px != want.px) begin
          $display("%0t pos_x exp %0d got %0d", $time, want.px, got.px); errors++;
        end
        if (got.py != want.py) begin
          $display("%0t pos_y exp %0d got %0d", $time, want.py, got.py); errors++;
        end
        if (got.pz != want.pz) begin
          $display("%0t pos_z exp %0d got %0d", $time, want.pz, got.pz); errors++;
        end
        if (got.fx != want.fx) begin
          $display("%0t front_x exp %0d got %0d", $time, want.fx, got.fx); errors++;
        end
        if (got.fy != want.fy) begin
          $display("%0t front_y exp %0d got %0d", $time, want.fy, got.fy); errors++;
        end
        if (got.fz != want.fz) begin
          $display("%0t front_z exp %0d got %0d", $time, want.fz, got.fz); errors++;
        end
        if (got.rx != want.rx) begin
          $display("%0t right_x exp %0d got %0d", $time, want.rx, got.rx); errors++;
        end
        if (got.ry != want.ry) begin
          $display("%0t right_y exp %0d got %0d", $time, want.ry, got.ry); errors++;
        end
        if (got.rz != want.rz) begin
          $display("%0t right_z exp %0d got %0d", $time, want.rz, got.rz); errors++;
        end
        if (got.ux != want.ux) begin
          $display("%0t up_x exp %0d got %0d", $time, want.ux, got.ux); errors++;
        end
        if (got.uy != want.uy) begin
          $display("%0t up_y exp %0d got %0d", $time, want.uy, got.uy); errors++;
        end
        if (got.uz != want.uz) begin
          $display("%0t up_z exp %0d got %0d", $time, want.uz, got.uz); errors++;
        end
      end
    end
  end

  function automatic logic [31:0] random_amount(flcb_pkg::op_e op);
    case (op)
      flcb_pkg::OP_ADD_YAW, flcb_pkg::OP_ADD_PITCH,
      flcb_pkg::OP_SET_YAW, flcb_pkg::OP_SET_PITCH:
        case ($urandom_range(3))
          0: return $urandom;
          1: return $urandom_range(12000) - 6000;
          default: return $urandom_range(1200) - 600;
        endcase
      default:
        case ($urandom_range(3))
          0: return $urandom;
          1: return $urandom_range(2000000) - 1000000;
          default: return $urandom_range(200000) - 100000;
        endcase
    endcase
  endfunction

  task automatic push_cmd(input flcb_pkg::op_e op, input logic [31:0] amt);
    cmd_t c;
    c.op = op;
    c.amount = amt;
    cmd_q.push_back(c);
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || s_axis_tvalid || view_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [12:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit = v;
  endtask

  task automatic random_phase(input int n);
    flcb_pkg::op_e op;
    for (int i = 0; i < n; i++) begin
      op = flcb_pkg::op_e'($urandom_range(15));
      push_cmd(op, random_amount(op));
    end
  endtask

  initial begin
    yaw = -64; pitch = 0; limit = 5696;
    pos[0] = 0; pos[1] = 0; pos[2] = 0;
    refresh_basis();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: every op, extremes, pitch cosine zero, wraps, saturation
    for (int o = 0; o < 16; o++) push_cmd(flcb_pkg::op_e'(o), 32'd65536);
    push_cmd(flcb_pkg::OP_SET_X, 32'h7fff_fff0);
    push_cmd(flcb_pkg::OP_ADD_X, 32'h7fff_ffff);
    push_cmd(flcb_pkg::OP_SET_Y, 32'h8000_0000);
    push_cmd(flcb_pkg::OP_BACK, 32'h7fff_ffff);
    push_cmd(flcb_pkg::OP_FWD, 32'h8000_0000);
    push_cmd(flcb_pkg::OP_SET_PITCH, 32'd5760);
    push_cmd(flcb_pkg::OP_ADD_YAW, 32'd11520);
    push_cmd(flcb_pkg::OP_RIGHT, 32'd100000);
    push_cmd(flcb_pkg::OP_ADD_PITCH, 32'h7fff_ffff);
    drain();
    write_limit(13'd5760);
    push_cmd(flcb_pkg::OP_ADD_PITCH, 32'h8000_0000);
    push_cmd(flcb_pkg::OP_SET_PITCH, 32'hffff_ffff);
    drain();
    write_limit(13'h1fff);
    push_cmd(flcb_pkg::OP_ADD_PITCH, 32'd9000);
    push_cmd(flcb_pkg::OP_LEFT, 32'd70000);
    drain();
    write_limit(13'd0);
    push_cmd(flcb_pkg::OP_ADD_PITCH, 32'd3000);
    drain();

    send_idle = 34; recv_idle = 83;
    write_limit(13'd2000);
    random_phase(200);
    drain();
    send_idle = 83; recv_idle = 34;
    write_limit(13'd5696);
    random_phase(200);
    drain();
    send_idle = 0; recv_idle = 0;
    write_limit(13'($urandom_range(8191)));
    random_phase(200);
    drain();

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
